/* src/assert_macros.svh */
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, held off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tsm_pkg.sv */
// Package with shared widths, codes and command types for the timestamp merge.
package tsm_pkg;
  localparam int NUM_SOURCES = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int SRC_W   = $clog2(NUM_SOURCES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = SRC_W + PTR_W;
  localparam int MEM_D   = NUM_SOURCES * QUEUE_DEPTH;
  localparam int TIME_W  = 64;
  localparam int TAG_W   = 32;
  localparam int FSRC_W  = 4;
  localparam int IN_W    = 104;
  localparam int OUT_W   = 104;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EARLY = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic load;    // capture input item
    logic check;   // decide push status
    logic scan;    // step the minimum search one source
    logic commit;  // apply push or pop, issue memory access
    logic refill;  // capture popped item from memory read, start new head time refill
    logic emit;    // load output register
  } tsm_cmd_t;

  typedef struct packed {
    logic is_pop;
    logic scan_done;
    logic out_busy;
  } tsm_stat_t;
endpackage

/* src/tsm_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/tsm_ctrl.sv */
// Controller FSM: capture, check or search, commit, refill, result.
module tsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  tsm_pkg::tsm_stat_t stat,
  output tsm_pkg::tsm_cmd_t  cmd,
  output logic              idle
);
  import tsm_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_REFILL = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    idle = 1'b0;
    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_pop) begin
          cmd.check = 1'b1;
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_done) state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = stat.is_pop ? S_REFILL : S_EMIT;
      end
      S_REFILL: begin
        cmd.refill = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  `ASSERT_IMPL(a_load_idle, cmd.load, state_r == S_IDLE, "load outside idle")
  `ASSERT_NEXT(a_commit_next, cmd.commit, state_r == S_REFILL || state_r == S_EMIT,
               "commit not followed by refill or emit")
  `ASSERT_NEXT(a_emit_idle, cmd.emit, state_r == S_IDLE, "emit not followed by idle")
endmodule

/* src/tsm_dp.sv */
// Datapath: per-source FIFO state, sequential minimum search, event memories.
module tsm_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsm_pkg::tsm_cmd_t       cmd,
  output tsm_pkg::tsm_stat_t      stat,
  input  logic [tsm_pkg::IN_W-1:0]  in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [tsm_pkg::OUT_W-1:0] out_tdata
);
  import tsm_pkg::*;
  `include "assert_macros.svh"

  logic [PTR_W-1:0]  head_r     [NUM_SOURCES];
  logic [CNT_W-1:0]  fill_r     [NUM_SOURCES];
  logic [TIME_W-1:0] head_time_r[NUM_SOURCES];

  // captured item
  logic              act_r;
  logic [FSRC_W-1:0] src_r;
  logic [TIME_W-1:0] time_r;
  logic [TAG_W-1:0]  tag_r;

  // search state
  logic [SRC_W-1:0]  scan_idx_r;
  logic              found_r;
  logic [SRC_W-1:0]  best_r;
  logic [TIME_W-1:0] best_time_r;

  logic [1:0]        status_r;
  logic              popped_r;

  logic              ovalid_r;
  logic [OUT_W-1:0]  odata_r;
  logic [OUT_W-1:0]  odata_nxt;

  // memories
  logic              mem_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [TIME_W-1:0] rd_time;
  logic [TAG_W-1:0]  rd_tag;

  logic              src_ok;
  logic [SRC_W-1:0]  psrc;
  logic [CNT_W-1:0]  pfill;
  logic [PTR_W-1:0]  wslot;
  logic [PTR_W-1:0]  bhead_nx;
  logic              any_pend;

  // refill reads the new head slot in the cycle after commit
  logic              refill_rd_r;
  logic [TIME_W-1:0] refill_time;

  assign src_ok = ({1'b0, src_r} < (FSRC_W+1)'(NUM_SOURCES));
  assign psrc   = src_r[SRC_W-1:0];
  assign pfill  = fill_r[psrc];
  assign wslot  = head_r[psrc] + pfill[PTR_W-1:0];
  assign bhead_nx = head_r[best_r] + PTR_W'(1);

  always_comb begin
    any_pend = 1'b0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      if (fill_r[s] != '0) any_pend = 1'b1;
    end
  end

  assign mem_we = cmd.commit && !act_r && status_r == ST_OK;
  assign waddr  = {psrc, wslot};
  // in commit of a pop read the popped slot; in refill read the new head
  assign raddr  = cmd.commit ? {best_r, head_r[best_r]} : {best_r, head_r[best_r]};

  tsm_ram #(.WIDTH(TIME_W), .DEPTH(MEM_D)) u_time_ram (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(time_r), .raddr(raddr), .rdata(rd_time)
  );
  tsm_ram #(.WIDTH(TAG_W), .DEPTH(MEM_D)) u_tag_ram (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(tag_r), .raddr(raddr), .rdata(rd_tag)
  );

  logic [TIME_W-1:0] pop_time_r;
  logic [TAG_W-1:0]  pop_tag_r;

  // result word: status, source, time, tag, pending from the lowest bit up
  always_comb begin
    odata_nxt = '0;
    odata_nxt[1:0] = status_r;
    odata_nxt[102] = any_pend;
    if (popped_r) begin
      odata_nxt[5:2] = FSRC_W'(best_r);
      odata_nxt[69:6] = pop_time_r;
      odata_nxt[101:70] = pop_tag_r;
    end
  end

  assign refill_time = rd_time;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SOURCES; s++) begin
        head_r[s] <= '0;
        fill_r[s] <= '0;
        head_time_r[s] <= '0;
      end
      ovalid_r <= 1'b0;
      scan_idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        act_r <= in_tdata[0];
        src_r <= in_tdata[4:1];
        time_r <= in_tdata[68:5];
        tag_r <= in_tdata[100:69];
        scan_idx_r <= '0;
        found_r <= 1'b0;
        best_r <= '0;
      end
      if (cmd.scan) begin
        if (fill_r[scan_idx_r] != '0 &&
            (!found_r || head_time_r[scan_idx_r] < best_time_r)) begin
          found_r <= 1'b1;
          best_r <= scan_idx_r;
          best_time_r <= head_time_r[scan_idx_r];
        end
        scan_idx_r <= scan_idx_r + SRC_W'(1);
      end
      if (cmd.commit) begin
        if (!act_r) begin
          if (status_r == ST_OK) begin
            if (pfill == '0) head_time_r[psrc] <= time_r;
            fill_r[psrc] <= pfill + CNT_W'(1);
          end
        end else if (found_r) begin
          head_r[best_r] <= bhead_nx;
          fill_r[best_r] <= fill_r[best_r] - CNT_W'(1);
        end
      end
      if (refill_rd_r) head_time_r[best_r] <= refill_time;
      if (cmd.refill) begin
        pop_time_r <= rd_time;
        pop_tag_r <= rd_tag;
      end
      if (cmd.emit) begin
        ovalid_r <= 1'b1;
        odata_r <= odata_nxt;
      end else if (out_tvalid && out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) refill_rd_r <= 1'b0;
    else refill_rd_r <= cmd.refill && fill_r[best_r] != '0;
  end

  // push status decided in check before commit; pop status set at commit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_r <= 1'b0;
    end else if (cmd.check) begin
      if (!src_ok || pfill >= CNT_W'(QUEUE_DEPTH)) begin
        status_r <= ST_FULL;
      end else if (pfill != '0 && time_r < head_time_r[psrc]) begin
        status_r <= ST_EARLY;
      end else begin
        status_r <= ST_OK;
      end
    end else if (cmd.commit && act_r) begin
      status_r <= found_r ? ST_OK : ST_EMPTY;
      popped_r <= found_r;
    end
  end

  assign stat.is_pop    = act_r;
  assign stat.scan_done = (scan_idx_r == SRC_W'(NUM_SOURCES - 1));
  assign stat.out_busy  = ovalid_r && !out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  `ASSERT_IMPL(a_no_overfill, mem_we, pfill < CNT_W'(QUEUE_DEPTH), "push into full queue")
  `ASSERT_IMPL(a_pop_nonempty, cmd.commit && act_r && found_r, fill_r[best_r] != '0,
               "pop from empty source")
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
               "stalled result changed")
endmodule

/* src/timestamp_merge_of_source_queues.sv */
// Top level of the timestamp merge of per-source event queues.
// Channel   | Dir | Ports                            | Contents
// in_       | in  | in_tvalid/in_tready/in_tdata     | action, source, event_time, event_tag
// out_      | out | out_tvalid/out_tready/out_tdata  | status, out_source, out_time, out_tag, pending
// A push passes through transfer in idle, check, commit and emit.
// A pop passes through transfer in idle, the minimum search visiting one source
// a cycle, commit with the head slot read, refill, emit.
// One item at a time; in_tready is high only while the controller is idle.
// Synchronous active-low reset empties all queues; event memories need no clearing.
// A stalled result holds in the output register and the block waits in emit.
module timestamp_merge_of_source_queues (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] action, [4:1] source, [68:5] event_time, [100:69] event_tag, [103:101] zero
  input  logic [tsm_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [1:0] status, [5:2] out_source, [69:6] out_time, [101:70] out_tag,
  // [102] pending, [103] zero
  output logic [tsm_pkg::OUT_W-1:0]  out_tdata
);
  import tsm_pkg::*;

  tsm_cmd_t  cmd;
  tsm_stat_t stat;
  logic      idle;

  // accept a new item only when the sequencer is back in idle
  assign in_tready = idle;

  tsm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready),
    .stat(stat), .cmd(cmd), .idle(idle)
  );

  tsm_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );
endmodule
